FILE: hw/rtl/vector_slerp_core_assert.svh
// Assertion macros used by the checker of the slerp core.
`ifndef VECTOR_SLERP_CORE_ASSERT_SVH
`define VECTOR_SLERP_CORE_ASSERT_SVH

// Implication checked only outside of reset.
`define VSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_slerp_core: check failed");

// Implication checked at every edge, reset included.
`define VSL_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("vector_slerp_core: check failed");

`endif

FILE: hw/rtl/vsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector slerp package
// Types, fixed-point constants and the arctangent table shared by the
// slerp core and its cells.
// ----------------------------------------------------------------------------
package vsl_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int HALF_PI_Q13  = 12868;
  localparam int PI_Q13       = 25736;
  localparam int GAIN_Q30     = 652032874;
  localparam int ONE_Q14      = 16384;
  localparam int SQRT_STEPS   = 15;
  localparam int DIV_STEPS    = 17;
  localparam logic [16:0] T_ONE = 17'd65536;

  typedef logic signed [15:0] comp_t;
  typedef comp_t [2:0] vec3_t;
  typedef logic signed [32:0] cord_t;
  typedef logic signed [16:0] ang_t;
  typedef logic [29:0] sqw_t;
  typedef logic [31:0] rem_t;
  typedef logic [16:0] quo_t;

  // Data that travels beside the arithmetic along the whole pipeline.
  typedef struct packed {
    vec3_t f;
    vec3_t g;
    logic [16:0] t;
    vec3_t lin;
    logic islin;
    logic [14:0] s;
    logic signed [15:0] c;
  } side_t;

  // Arctangent of 2^-i in Q3.13.
  function automatic ang_t atan_q13(input int idx);
    unique case (idx)
      0: return 17'sd6434;
      1: return 17'sd3798;
      2: return 17'sd2007;
      3: return 17'sd1019;
      4: return 17'sd511;
      5: return 17'sd256;
      6: return 17'sd128;
      7: return 17'sd64;
      8: return 17'sd32;
      9: return 17'sd16;
      10: return 17'sd8;
      11: return 17'sd4;
      12: return 17'sd2;
      13: return 17'sd1;
      default: return 17'sd0;
    endcase
  endfunction

  // Saturate a 20-bit signed value to a Q2.14 component.
  function automatic comp_t sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

FILE: hw/rtl/vsl_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One bit-pair step of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module vsl_sqrt_cell import vsl_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  sqw_t  v_i,
  input  sqw_t  r_i,
  input  side_t sd_i,
  output logic  vld_o,
  output sqw_t  v_o,
  output sqw_t  r_o,
  output side_t sd_o
);

  localparam sqw_t BIT = sqw_t'(1) << (2 * K);

  logic  vld_r;
  sqw_t  v_r, v_nxt, r_r, r_nxt, trial;
  side_t sd_r;

  // Try to take the current bit into the root.
  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    r_r  <= r_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign v_o   = v_r;
  assign r_o   = r_r;
  assign sd_o  = sd_r;

endmodule

FILE: hw/rtl/vsl_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation that drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
module vsl_vec_cell import vsl_pkg::*; #(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  cord_t x_i,
  input  cord_t y_i,
  input  ang_t  z_i,
  input  side_t sd_i,
  output logic  vld_o,
  output cord_t x_o,
  output cord_t y_o,
  output ang_t  z_o,
  output side_t sd_o
);

  localparam ang_t AT = atan_q13(I);

  logic  vld_r;
  cord_t x_r, y_r, x_nxt, y_nxt;
  ang_t  z_r, z_nxt;
  side_t sd_r;

  // Rotate toward the x axis by the step angle.
  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> I);
      y_nxt = y_i - (x_i >>> I);
      z_nxt = z_i + AT;
    end else begin
      x_nxt = x_i - (y_i >>> I);
      y_nxt = y_i + (x_i >>> I);
      z_nxt = z_i - AT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign sd_o  = sd_r;

endmodule

FILE: hw/rtl/vsl_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation for each of the two partial-angle sine lanes.
// ----------------------------------------------------------------------------
module vsl_rot_cell import vsl_pkg::*; #(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  cord_t x_i [2],
  input  cord_t y_i [2],
  input  ang_t  z_i [2],
  input  side_t sd_i,
  output logic  vld_o,
  output cord_t x_o [2],
  output cord_t y_o [2],
  output ang_t  z_o [2],
  output side_t sd_o
);

  localparam ang_t AT = atan_q13(I);

  logic  vld_r;
  cord_t x_r [2], y_r [2], x_nxt [2], y_nxt [2];
  ang_t  z_r [2], z_nxt [2];
  side_t sd_r;

  // Turn each lane toward its residual angle.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (z_i[l] >= 0) begin
        x_nxt[l] = x_i[l] - (y_i[l] >>> I);
        y_nxt[l] = y_i[l] + (x_i[l] >>> I);
        z_nxt[l] = z_i[l] - AT;
      end else begin
        x_nxt[l] = x_i[l] + (y_i[l] >>> I);
        y_nxt[l] = y_i[l] - (x_i[l] >>> I);
        z_nxt[l] = z_i[l] + AT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign sd_o  = sd_r;

endmodule

FILE: hw/rtl/vsl_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring divide by the sine, for all three lanes.
// ----------------------------------------------------------------------------
module vsl_div_cell import vsl_pkg::*; #(
  parameter int K = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       vld_i,
  input  rem_t       rem_i [3],
  input  quo_t       q_i [3],
  input  logic [2:0] neg_i,
  input  side_t      sd_i,
  output logic       vld_o,
  output rem_t       rem_o [3],
  output quo_t       q_o [3],
  output logic [2:0] neg_o,
  output side_t      sd_o
);

  logic       vld_r;
  rem_t       rem_r [3], rem_nxt [3];
  quo_t       q_r [3], q_nxt [3];
  logic [2:0] neg_r;
  side_t      sd_r;
  rem_t       dv;

  // Subtract the shifted divisor where it fits.
  always_comb begin
    dv = rem_t'(sd_i.s) << K;
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k] >= dv) begin
        rem_nxt[k] = rem_i[k] - dv;
        q_nxt[k]   = q_i[k] | (quo_t'(1) << K);
      end else begin
        rem_nxt[k] = rem_i[k];
        q_nxt[k]   = q_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_i;
    sd_r  <= sd_i;
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign neg_o = neg_r;
  assign sd_o  = sd_r;

endmodule

FILE: hw/rtl/vector_slerp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector slerp core
// Spherical interpolation of two Q2.14 3-D vectors by a Q1.16 factor.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the factor and both vectors on the in_ ports and raise start; the
//   beat is taken at any edge where start is high and busy is low. busy stays
//   low, so a new beat can be taken at every clock.
//   Each beat gives one result beat on out_x/out_y/out_z/out_used_linear,
//   shown for exactly one cycle with out_valid high. The receiver cannot
//   stall the core and must take each result beat when it appears.
//   The pipeline is made of the 15-cell square root chain, the two CORDIC
//   chains of TRIG_ITERATIONS cells each (at most ATAN_ENTRIES), the 17-cell
//   divider chain and the registered stages between them.
//   Throughput is one beat per cycle.
//   A synchronous reset (rst_n low) empties the pipeline; beats in flight
//   are dropped and no result beat appears for them.
// ----------------------------------------------------------------------------
module vector_slerp_core import vsl_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] in_factor,
  input  comp_t       in_from_x,
  input  comp_t       in_from_y,
  input  comp_t       in_from_z,
  input  comp_t       in_to_x,
  input  comp_t       in_to_y,
  input  comp_t       in_to_z,
  output logic        out_valid,
  output comp_t       out_x,
  output comp_t       out_y,
  output comp_t       out_z,
  output logic        out_used_linear
);

  localparam int NIT = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

  logic acc;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // Capture stage: clamp the factor and form the dot product terms.
  logic               p0_vld_r;
  side_t              p0_sd_r, p0_sd_nxt;
  logic signed [31:0] p0_pd_r [3];

  always_comb begin
    p0_sd_nxt      = '0;
    p0_sd_nxt.f[0] = in_from_x;
    p0_sd_nxt.f[1] = in_from_y;
    p0_sd_nxt.f[2] = in_from_z;
    p0_sd_nxt.g[0] = in_to_x;
    p0_sd_nxt.g[1] = in_to_y;
    p0_sd_nxt.g[2] = in_to_z;
    p0_sd_nxt.t    = (in_factor > T_ONE) ? T_ONE : in_factor;
  end

  always_ff @(posedge clk) begin
    p0_sd_r    <= p0_sd_nxt;
    p0_pd_r[0] <= in_from_x * in_to_x;
    p0_pd_r[1] <= in_from_y * in_to_y;
    p0_pd_r[2] <= in_from_z * in_to_z;
  end

  // Cosine stage: round and clamp the dot product, form the linear terms.
  logic               p1_vld_r;
  side_t              p1_sd_r, p1_sd_nxt;
  logic signed [34:0] p1_lin_r [3], p1_lin_nxt [3];
  logic signed [33:0] dot, cr;
  logic signed [16:0] diff;

  always_comb begin
    p1_sd_nxt = p0_sd_r;
    dot = 34'(p0_pd_r[0]) + 34'(p0_pd_r[1]) + 34'(p0_pd_r[2]);
    cr  = (dot + 34'sd8192) >>> 14;
    if (cr > 34'sd16384) begin
      p1_sd_nxt.c = 16'sd16384;
    end else if (cr < -34'sd16384) begin
      p1_sd_nxt.c = -16'sd16384;
    end else begin
      p1_sd_nxt.c = cr[15:0];
    end
    diff = '0;
    for (int k = 0; k < 3; k++) begin
      diff          = 17'(p0_sd_r.g[k]) - 17'(p0_sd_r.f[k]);
      p1_lin_nxt[k] = 35'(diff) * 35'($signed({1'b0, p0_sd_r.t}));
    end
  end

  always_ff @(posedge clk) begin
    p1_sd_r  <= p1_sd_nxt;
    p1_lin_r <= p1_lin_nxt;
  end

  // Sine-squared stage: 1 - c^2, linear blend result and fallback flag.
  logic               p2_vld_r;
  side_t              p2_sd_r, p2_sd_nxt;
  sqw_t               p2_v_r, p2_v_nxt;
  logic signed [31:0] csq;
  logic signed [34:0] lsh;

  always_comb begin
    p2_sd_nxt = p1_sd_r;
    csq       = 32'(p1_sd_r.c) * 32'(p1_sd_r.c);
    p2_v_nxt  = sqw_t'(30'd268435456 - csq[29:0]);
    p2_sd_nxt.islin = (p1_sd_r.c == 16'(ONE_Q14)) || (p1_sd_r.c == -16'(ONE_Q14));
    lsh = '0;
    for (int k = 0; k < 3; k++) begin
      lsh = (p1_lin_r[k] + 35'sd32768) >>> 16;
      p2_sd_nxt.lin[k] = sat16(20'(p1_sd_r.f[k]) + 20'(lsh));
    end
  end

  always_ff @(posedge clk) begin
    p2_sd_r <= p2_sd_nxt;
    p2_v_r  <= p2_v_nxt;
  end

  // Square root chain.
  wire       sq_vld [0:SQRT_STEPS];
  wire sqw_t sq_v [0:SQRT_STEPS];
  wire sqw_t sq_r [0:SQRT_STEPS];
  wire side_t sq_sd [0:SQRT_STEPS];

  assign sq_vld[0] = p2_vld_r;
  assign sq_v[0]   = p2_v_r;
  assign sq_r[0]   = '0;
  assign sq_sd[0]  = p2_sd_r;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    vsl_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (sq_vld[j]),
      .v_i   (sq_v[j]),
      .r_i   (sq_r[j]),
      .sd_i  (sq_sd[j]),
      .vld_o (sq_vld[j+1]),
      .v_o   (sq_v[j+1]),
      .r_o   (sq_r[j+1]),
      .sd_o  (sq_sd[j+1])
    );
  end

  // Vectoring setup: place (c, s) in the right half plane.
  logic  p3_vld_r;
  side_t p3_sd_r, p3_sd_nxt;
  cord_t p3_x_r, p3_y_r, p3_x_nxt, p3_y_nxt;
  ang_t  p3_z_r, p3_z_nxt;

  always_comb begin
    p3_sd_nxt   = sq_sd[SQRT_STEPS];
    p3_sd_nxt.s = sq_r[SQRT_STEPS][14:0];
    if (p3_sd_nxt.c < 0) begin
      p3_x_nxt = cord_t'(p3_sd_nxt.s) <<< 16;
      p3_y_nxt = (-cord_t'(p3_sd_nxt.c)) <<< 16;
      p3_z_nxt = ang_t'(HALF_PI_Q13);
    end else begin
      p3_x_nxt = cord_t'(p3_sd_nxt.c) <<< 16;
      p3_y_nxt = cord_t'(p3_sd_nxt.s) <<< 16;
      p3_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    p3_sd_r <= p3_sd_nxt;
    p3_x_r  <= p3_x_nxt;
    p3_y_r  <= p3_y_nxt;
    p3_z_r  <= p3_z_nxt;
  end

  // Vectoring chain.
  wire        vc_vld [0:NIT];
  wire cord_t vc_x [0:NIT];
  wire cord_t vc_y [0:NIT];
  wire ang_t  vc_z [0:NIT];
  wire side_t vc_sd [0:NIT];

  assign vc_vld[0] = p3_vld_r;
  assign vc_x[0]   = p3_x_r;
  assign vc_y[0]   = p3_y_r;
  assign vc_z[0]   = p3_z_r;
  assign vc_sd[0]  = p3_sd_r;

  for (genvar j = 0; j < NIT; j++) begin : g_vec
    vsl_vec_cell #(.I(j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vc_vld[j]),
      .x_i   (vc_x[j]),
      .y_i   (vc_y[j]),
      .z_i   (vc_z[j]),
      .sd_i  (vc_sd[j]),
      .vld_o (vc_vld[j+1]),
      .x_o   (vc_x[j+1]),
      .y_o   (vc_y[j+1]),
      .z_o   (vc_z[j+1]),
      .sd_o  (vc_sd[j+1])
    );
  end

  // Angle stage: clamp the angle and scale it by t and 1 - t.
  logic        p4_vld_r;
  side_t       p4_sd_r;
  logic [31:0] p4_ta_r, p4_ua_r;
  logic [14:0] ang;

  always_comb begin
    if (vc_z[NIT] < 0) begin
      ang = '0;
    end else if (vc_z[NIT] > ang_t'(PI_Q13)) begin
      ang = 15'(PI_Q13);
    end else begin
      ang = vc_z[NIT][14:0];
    end
  end

  always_ff @(posedge clk) begin
    p4_sd_r <= vc_sd[NIT];
    p4_ta_r <= 32'(vc_sd[NIT].t) * 32'(ang);
    p4_ua_r <= 32'(T_ONE - vc_sd[NIT].t) * 32'(ang);
  end

  // Partial angle stage: round and fold above a quarter turn.
  logic        p5_vld_r;
  side_t       p5_sd_r;
  ang_t        p5_th_r [2], p5_th_nxt [2];
  logic [31:0] prd [2];
  logic [15:0] th;

  always_comb begin
    prd[0] = p4_ua_r + 32'd32768;
    prd[1] = p4_ta_r + 32'd32768;
    th     = '0;
    for (int l = 0; l < 2; l++) begin
      th = prd[l][31:16];
      if (th > 16'(HALF_PI_Q13)) begin
        p5_th_nxt[l] = ang_t'(16'(PI_Q13) - th);
      end else begin
        p5_th_nxt[l] = ang_t'(th);
      end
    end
  end

  always_ff @(posedge clk) begin
    p5_sd_r <= p4_sd_r;
    p5_th_r <= p5_th_nxt;
  end

  // Rotation chain, lane 0 for (1 - t) a and lane 1 for t a.
  wire        rt_vld [0:NIT];
  wire cord_t rt_x [0:NIT][2];
  wire cord_t rt_y [0:NIT][2];
  wire ang_t  rt_z [0:NIT][2];
  wire side_t rt_sd [0:NIT];

  assign rt_vld[0]  = p5_vld_r;
  assign rt_x[0][0] = cord_t'(GAIN_Q30);
  assign rt_x[0][1] = cord_t'(GAIN_Q30);
  assign rt_y[0][0] = '0;
  assign rt_y[0][1] = '0;
  assign rt_z[0][0] = p5_th_r[0];
  assign rt_z[0][1] = p5_th_r[1];
  assign rt_sd[0]   = p5_sd_r;

  for (genvar j = 0; j < NIT; j++) begin : g_rot
    vsl_rot_cell #(.I(j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (rt_vld[j]),
      .x_i   (rt_x[j]),
      .y_i   (rt_y[j]),
      .z_i   (rt_z[j]),
      .sd_i  (rt_sd[j]),
      .vld_o (rt_vld[j+1]),
      .x_o   (rt_x[j+1]),
      .y_o   (rt_y[j+1]),
      .z_o   (rt_z[j+1]),
      .sd_o  (rt_sd[j+1])
    );
  end

  // Weighting stage: scale both vectors by their sines.
  logic               p6_vld_r;
  side_t              p6_sd_r;
  logic signed [48:0] p6_fs_r [3], p6_gs_r [3];

  always_ff @(posedge clk) begin
    p6_sd_r <= rt_sd[NIT];
    for (int k = 0; k < 3; k++) begin
      p6_fs_r[k] <= 49'(rt_sd[NIT].f[k]) * 49'(rt_y[NIT][0]);
      p6_gs_r[k] <= 49'(rt_sd[NIT].g[k]) * 49'(rt_y[NIT][1]);
    end
  end

  // Sum stage.
  logic               p7_vld_r;
  side_t              p7_sd_r;
  logic signed [49:0] p7_num_r [3];

  always_ff @(posedge clk) begin
    p7_sd_r <= p6_sd_r;
    for (int k = 0; k < 3; k++) begin
      p7_num_r[k] <= 50'(p6_fs_r[k]) + 50'(p6_gs_r[k]);
    end
  end

  // Dividend stage: magnitude plus half the divisor, scaled down by 2^16.
  logic        p8_vld_r;
  side_t       p8_sd_r;
  rem_t        p8_rem_r [3], p8_rem_nxt [3];
  logic [2:0]  p8_neg_r, p8_neg_nxt;
  logic [49:0] mag;

  always_comb begin
    mag = '0;
    for (int k = 0; k < 3; k++) begin
      p8_neg_nxt[k] = p7_num_r[k][49];
      mag = p8_neg_nxt[k] ? 50'(-p7_num_r[k]) : 50'(p7_num_r[k]);
      mag = mag + (50'(p7_sd_r.s) << 15);
      p8_rem_nxt[k] = mag[47:16];
    end
  end

  always_ff @(posedge clk) begin
    p8_sd_r  <= p7_sd_r;
    p8_rem_r <= p8_rem_nxt;
    p8_neg_r <= p8_neg_nxt;
  end

  // Divider chain; the top quotient bit marks overflow.
  wire             dv_vld [0:DIV_STEPS];
  wire rem_t       dv_rem [0:DIV_STEPS][3];
  wire quo_t       dv_q [0:DIV_STEPS][3];
  wire logic [2:0] dv_neg [0:DIV_STEPS];
  wire side_t      dv_sd [0:DIV_STEPS];

  assign dv_vld[0] = p8_vld_r;
  assign dv_rem[0] = p8_rem_r;
  assign dv_q[0][0] = '0;
  assign dv_q[0][1] = '0;
  assign dv_q[0][2] = '0;
  assign dv_neg[0] = p8_neg_r;
  assign dv_sd[0]  = p8_sd_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    vsl_div_cell #(.K(DIV_STEPS - 1 - j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (dv_vld[j]),
      .rem_i (dv_rem[j]),
      .q_i   (dv_q[j]),
      .neg_i (dv_neg[j]),
      .sd_i  (dv_sd[j]),
      .vld_o (dv_vld[j+1]),
      .rem_o (dv_rem[j+1]),
      .q_o   (dv_q[j+1]),
      .neg_o (dv_neg[j+1]),
      .sd_o  (dv_sd[j+1])
    );
  end

  // Output stage: apply sign, saturate and pick the linear fallback.
  logic  out_valid_r, out_lin_r;
  vec3_t out_v_r, out_v_nxt;
  side_t fsd;
  quo_t  qv;

  always_comb begin
    fsd = dv_sd[DIV_STEPS];
    qv  = '0;
    for (int k = 0; k < 3; k++) begin
      qv = dv_q[DIV_STEPS][k];
      if (fsd.islin) begin
        out_v_nxt[k] = fsd.lin[k];
      end else if (dv_neg[DIV_STEPS][k]) begin
        if (qv > 17'd32768) begin
          out_v_nxt[k] = 16'sh8000;
        end else begin
          out_v_nxt[k] = 16'(-qv);
        end
      end else if (qv > 17'd32767) begin
        out_v_nxt[k] = 16'sh7fff;
      end else begin
        out_v_nxt[k] = qv[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_v_r   <= out_v_nxt;
    out_lin_r <= fsd.islin;
  end

  // Valid bits of the stages outside the cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r    <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      p5_vld_r    <= 1'b0;
      p6_vld_r    <= 1'b0;
      p7_vld_r    <= 1'b0;
      p8_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p0_vld_r    <= acc;
      p1_vld_r    <= p0_vld_r;
      p2_vld_r    <= p1_vld_r;
      p3_vld_r    <= sq_vld[SQRT_STEPS];
      p4_vld_r    <= vc_vld[NIT];
      p5_vld_r    <= p4_vld_r;
      p6_vld_r    <= rt_vld[NIT];
      p7_vld_r    <= p6_vld_r;
      p8_vld_r    <= p7_vld_r;
      out_valid_r <= dv_vld[DIV_STEPS];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_v_r[0];
  assign out_y           = out_v_r[1];
  assign out_z           = out_v_r[2];
  assign out_used_linear = out_lin_r;

endmodule

FILE: hw/rtl/vsl_checker.sv
`timescale 1ns / 1ps
`include "vector_slerp_core_assert.svh"
// ----------------------------------------------------------------------------
// Vector slerp checker
// Port-level checks of latency and of the linear fallback, bound to the core.
// ----------------------------------------------------------------------------
module vsl_checker import vsl_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [16:0] in_factor,
  input comp_t       in_from_x,
  input comp_t       in_from_y,
  input comp_t       in_from_z,
  input comp_t       in_to_x,
  input comp_t       in_to_y,
  input comp_t       in_to_z,
  input logic        out_valid,
  input comp_t       out_x,
  input comp_t       out_y,
  input comp_t       out_z,
  input logic        out_used_linear
);

  localparam int NIT = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int LAT = 2 * NIT + 42;
  localparam int CW  = $clog2(LAT + 1);

  logic [CW-1:0] rcnt_r;

  // Count edges since reset was last low, saturating at the latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r <= '0;
    end else if (rcnt_r != CW'(LAT)) begin
      rcnt_r <= rcnt_r + 1'b1;
    end
  end

  // Every result beat comes from a beat taken exactly one latency earlier.
  `VSL_ASSERT_IMP(a_result_has_beat, out_valid, $past(start && !busy, LAT))

  // A beat taken with no reset since gives its result on time.
  `VSL_ASSERT_ALWAYS(a_beat_has_result, (rcnt_r == CW'(LAT)) && $past(start && !busy, LAT), out_valid)

  // Equal unit vectors along x take the linear fallback.
  `VSL_ASSERT_IMP(a_parallel_linear, out_valid && $past(in_from_x == 16'sd16384 && in_from_y == 16'sd0 && in_from_z == 16'sd0 && in_to_x == 16'sd16384 && in_to_y == 16'sd0 && in_to_z == 16'sd0, LAT), out_used_linear)

  // The linear blend at a zero factor returns the start vector.
  `VSL_ASSERT_IMP(a_linear_zero_factor, out_valid && out_used_linear && $past(in_factor == 17'd0, LAT), out_x == $past(in_from_x, LAT) && out_y == $past(in_from_y, LAT) && out_z == $past(in_from_z, LAT))

endmodule

bind vector_slerp_core vsl_checker #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_vsl_checker (.*);

FILE: dv/vector_slerp_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector slerp core testbench
// Sends directed and random factor/vector beats through the slerp core,
// predicts each result with a bit-exact fixed-point model of the CORDIC,
// square root and divide arithmetic, and checks every result beat in order.
// ----------------------------------------------------------------------------
module vector_slerp_core_test import vsl_pkg::*;;

  localparam int TRIG_ITERATIONS = 16;
  localparam int LATENCY = 2 * TRIG_ITERATIONS + 42;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  lin;
  } blend_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [16:0] in_factor = '0;
  comp_t       in_from_x = '0;
  comp_t       in_from_y = '0;
  comp_t       in_from_z = '0;
  comp_t       in_to_x = '0;
  comp_t       in_to_y = '0;
  comp_t       in_to_z = '0;
  logic        out_valid;
  comp_t       out_x;
  comp_t       out_y;
  comp_t       out_z;
  logic        out_used_linear;

  blend_t expected_blends[$];
  int     mismatches = 0;
  int     idle_pct = 0;

  vector_slerp_core #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dut (.*);

  always #2 clk = ~clk;

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r = 0;
    longint b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 14) ? tbl[i] : 0;
  endfunction

  // Angle in Q3.13 from a cosine and sine pair by CORDIC vectoring.
  function automatic longint cordic_angle(longint c, longint s);
    longint x, y, z, nx, ny;
    int n = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
    if (c < 0) begin
      x = s * 65536; y = -c * 65536; z = HALF_PI_Q13;
    end else begin
      x = c * 65536; y = s * 65536; z = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += atan_step(i);
      end else begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= atan_step(i);
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > PI_Q13) z = PI_Q13;
    return z;
  endfunction

  // Sine in Q2.30 of a Q3.13 angle by CORDIC rotation.
  function automatic longint cordic_sine(longint theta);
    longint x = GAIN_Q30, y = 0, z, nx, ny;
    int n = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
    if (theta > HALF_PI_Q13) theta = PI_Q13 - theta;
    z = theta;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= atan_step(i);
      end else begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += atan_step(i);
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  function automatic blend_t predict_blend(logic [16:0] fac, comp_t f[3], comp_t g[3]);
    blend_t b;
    longint t, dot, c, s, a, s1, s2, d, num, q;
    longint r[3];
    t = (fac > T_ONE) ? 65536 : longint'(fac);
    dot = 0;
    for (int k = 0; k < 3; k++) dot += longint'(f[k]) * longint'(g[k]);
    c = shr_floor(dot + 8192, 14);
    if (c > ONE_Q14) c = ONE_Q14;
    if (c < -ONE_Q14) c = -ONE_Q14;
    if (c == ONE_Q14 || c == -ONE_Q14) begin
      for (int k = 0; k < 3; k++)
        r[k] = clip16(f[k] + shr_floor((longint'(g[k]) - f[k]) * t + 32768, 16));
      b.lin = 1'b1;
    end else begin
      s = int_sqrt(268435456 - c * c);
      a = cordic_angle(c, s);
      s1 = cordic_sine(shr_floor((65536 - t) * a + 32768, 16));
      s2 = cordic_sine(shr_floor(t * a + 32768, 16));
      d = s * 65536;
      for (int k = 0; k < 3; k++) begin
        num = longint'(f[k]) * s1 + longint'(g[k]) * s2;
        if (num >= 0) q = (num + d / 2) / d;
        else q = -((-num + d / 2) / d);
        r[k] = clip16(q);
      end
      b.lin = 1'b0;
    end
    b.x = r[0][15:0]; b.y = r[1][15:0]; b.z = r[2][15:0];
    return b;
  endfunction

  // Sends one beat and records its prediction at the accepting edge.
  // start is left high so that the next beat can follow without a gap.
  task automatic send_beat(logic [16:0] fac, comp_t f[3], comp_t g[3]);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_factor <= fac;
    in_from_x <= f[0]; in_from_y <= f[1]; in_from_z <= f[2];
    in_to_x <= g[0]; in_to_y <= g[1]; in_to_z <= g[2];
    do @(posedge clk); while (busy);
    expected_blends.push_back(predict_blend(fac, f, g));
    @(negedge clk);
  endtask

  // Checks every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d lin=%0b",
                 $time, out_x, out_y, out_z, out_used_linear);
        mismatches++;
      end else begin
        blend_t e;
        e = expected_blends.pop_front();
        if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.lin !== out_used_linear) begin
          $display("%0t: expected x=%0d y=%0d z=%0d lin=%0b, actual x=%0d y=%0d z=%0d lin=%0b",
                   $time, e.x, e.y, e.z, e.lin, out_x, out_y, out_z, out_used_linear);
          mismatches++;
        end
      end
    end
  end

  // Random unit-ish vector on a coarse sphere, or raw noise.
  function automatic void random_vec(output comp_t v[3], input bit raw);
    real th, ph, m;
    if (raw) begin
      for (int k = 0; k < 3; k++) v[k] = comp_t'($urandom());
      return;
    end
    th = $urandom_range(0, 62831) / 10000.0;
    ph = $urandom_range(0, 31415) / 10000.0;
    m = 16384.0 + $urandom_range(0, 40) - 20;
    v[0] = comp_t'($rtoi(m * $sin(ph) * $cos(th)));
    v[1] = comp_t'($rtoi(m * $sin(ph) * $sin(th)));
    v[2] = comp_t'($rtoi(m * $cos(ph)));
  endfunction

  function automatic logic [16:0] random_factor();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return T_ONE;
      2: return 17'(65536 + $urandom_range(1, 65535));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic test_directed();
    comp_t ux[3] = '{16'sd16384, 16'sd0, 16'sd0};
    comp_t uy[3] = '{16'sd0, 16'sd16384, 16'sd0};
    comp_t nx[3] = '{-16'sd16384, 16'sd0, 16'sd0};
    comp_t mx[3] = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    comp_t mn[3] = '{16'sh8000, 16'sh8000, 16'sh8000};
    comp_t zr[3] = '{16'sd0, 16'sd0, 16'sd0};
    comp_t d1[3] = '{16'sd11585, 16'sd11585, 16'sd0};
    // Perpendicular vectors across the factor range, factor above one included.
    send_beat(17'd0, ux, uy);
    send_beat(17'd32768, ux, uy);
    send_beat(T_ONE, ux, uy);
    send_beat(17'h1ffff, ux, uy);
    send_beat(17'd65537, ux, uy);
    // Parallel and antipodal vectors take the linear blend.
    send_beat(17'd16384, ux, ux);
    send_beat(17'd32768, ux, nx);
    send_beat(17'd65536, nx, ux);
    // Vectors far from unit length, zero vectors and a diagonal unit vector.
    send_beat(17'd32768, mx, mx);
    send_beat(17'd32768, mn, mn);
    send_beat(17'd32768, mx, mn);
    send_beat(17'd1, mn, mx);
    send_beat(17'd32768, zr, zr);
    send_beat(17'd40000, zr, ux);
    send_beat(17'd20000, ux, d1);
    send_beat(17'd50000, d1, nx);
    send_beat(17'd65535, mx, uy);
  endtask

  task automatic test_random(int count, int pct);
    comp_t f[3], g[3];
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      random_vec(f, $urandom_range(9) == 0);
      case ($urandom_range(7))
        0: g = f;
        1: for (int k = 0; k < 3; k++) g[k] = -f[k];
        default: random_vec(g, $urandom_range(9) == 0);
      endcase
      send_beat(random_factor(), f, g);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(150, 0);
    test_random(150, 69);
    test_random(150, 10);
    test_random(150, 0);
    start <= 1'b0;
    while (expected_blends.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("vector_slerp_core regression: pass");
    end else begin
      $display("vector_slerp_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vector_slerp_core regression: fail");
    $finish;
  end

endmodule
